// ===== hw/rtl/lge_pkg.sv =====
// Shared constants and the B3/S23 cell rule for the life grid engine.
// Depends on nothing; imported by the top level of the engine.
`default_nettype none

package lge_pkg;

  // Default grid size.
  localparam int unsigned GRID_COLS_DEF = 64;
  localparam int unsigned GRID_ROWS_DEF = 64;

  // Widths of the stream fields.
  localparam int unsigned CMD_FW = 2;
  localparam int unsigned COL_FW = 6;
  localparam int unsigned ROW_FW = 6;
  localparam int unsigned POP_FW = 13;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // Reported population saturates here.
  localparam int unsigned POP_MAX = 8191;

  // Rule constants.
  localparam int unsigned BIRTH_COUNT = 3;
  localparam int unsigned SURVIVE_LOW = 2;

  // Command codes; any other code reads.
  localparam logic [CMD_FW-1:0] CMD_READ   = 2'd0;
  localparam logic [CMD_FW-1:0] CMD_TOGGLE = 2'd1;
  localparam logic [CMD_FW-1:0] CMD_STEP   = 2'd2;

  // Next state of one cell from itself and its live neighbor count.
  function automatic logic life_next(input logic self, input logic [3:0] nbrs);
    logic born;
    logic keep;
    born = (nbrs == 4'(BIRTH_COUNT));
    keep = self && (nbrs == 4'(SURVIVE_LOW));
    return born || keep;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lge_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module lge_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/life_grid_engine_core.sv =====
// Top level of the life grid engine: stream ports, command sequencer, generation sweep.
// Depends on lge_pkg and lge_ram.
`default_nettype none

// Life grid engine. Holds a GRID_COLS by GRID_ROWS grid of one-bit cells under the
// B3/S23 rule, with dead cells beyond the edges (no wrap). Each input word carries
// cmd, col and row: cmd 0 reads the addressed cell, cmd 1 toggles it, cmd 2 advances
// the whole grid one generation, and cmd 3 acts as a read. Each input word yields
// exactly one output word with the addressed cell after the operation (0 when the
// address lies outside the grid) and the live population, saturated at 8191.
// The grid lives in one RAM of whole rows, split into two banks: a generation reads
// the current bank through a three-row window and writes the next bank, then the
// banks swap. After reset the engine zeroes every row of bank 0 and holds s_tready
// low meanwhile. A read or toggle passes through accept, row read, modify and output
// load. A step passes through accept, the generation sweep, then the same row read,
// modify and output load. The sweep evaluates one cell per cycle and spends a row
// read and a write-back on each row. One word is in flight at a time; the output
// register lets the next word be accepted while the previous result still waits on
// m_tready.
module life_grid_engine_core
  import lge_pkg::*;
#(
  parameter int unsigned GRID_COLS = GRID_COLS_DEF,
  parameter int unsigned GRID_ROWS = GRID_ROWS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // cmd[1:0], col[7:2], row[13:8], zero pad
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic      [OUT_TDATA_W-1:0] m_tdata   // alive[0], population[13:1], zero pad
);

  localparam int unsigned COL_W  = $clog2(GRID_COLS);
  localparam int unsigned ROW_W  = $clog2(GRID_ROWS);
  localparam int unsigned LDR_W  = $clog2(GRID_ROWS + 1);
  localparam int unsigned POP_W  = $clog2(GRID_COLS * GRID_ROWS + 1);
  localparam int unsigned CIW    = ((COL_W > COL_FW) ? COL_W : COL_FW) + 1;
  localparam int unsigned RIW    = ((ROW_W > ROW_FW) ? ROW_W : ROW_FW) + 1;
  localparam int unsigned PW     = (POP_W > POP_FW) ? POP_W : POP_FW;
  localparam int unsigned MEM_AW = ROW_W + 1;

  // Sequencer states.
  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CRD   = 4'd2;
  localparam logic [3:0] ST_CDAT  = 4'd3;
  localparam logic [3:0] ST_RESP  = 4'd4;
  localparam logic [3:0] ST_SRD   = 4'd5;
  localparam logic [3:0] ST_SLD   = 4'd6;
  localparam logic [3:0] ST_SCOL  = 4'd7;
  localparam logic [3:0] ST_SWR   = 4'd8;

  logic [3:0]           state;
  logic [ROW_W-1:0]     clr_row;
  logic                 bank;
  logic [POP_W-1:0]     live_count;

  // Latched command word.
  logic [CMD_FW-1:0]    cmd_q;
  logic [COL_FW-1:0]    col_q;
  logic [ROW_FW-1:0]    row_q;
  logic                 res_alive;

  // Generation sweep: three-row window, left-column bits, assembled next row.
  logic [LDR_W-1:0]     ld_row;
  logic [COL_W-1:0]     col_cnt;
  logic [GRID_COLS-1:0] a_row;
  logic [GRID_COLS-1:0] c_row;
  logic [GRID_COLS-1:0] b_row;
  logic [GRID_COLS-1:0] new_row;
  logic                 la;
  logic                 lc;
  logic                 lb;
  logic [POP_W-1:0]     pop_acc;

  // RAM ports.
  logic                 mem_we;
  logic [MEM_AW-1:0]    mem_waddr;
  logic [GRID_COLS-1:0] mem_wdata;
  logic [MEM_AW-1:0]    mem_raddr;
  logic [GRID_COLS-1:0] mem_rdata;

  // Address decode of the latched word.
  logic [CIW-1:0]       col_wide;
  logic [RIW-1:0]       row_wide;
  logic                 on_grid;
  logic [COL_W-1:0]     col_idx;
  logic [ROW_W-1:0]     row_idx;
  logic [GRID_COLS-1:0] col_mask;
  logic                 cur_bit;
  logic                 do_toggle;

  logic                 last_col;
  logic [3:0]           nbrs;
  logic                 cell_next;
  logic [PW-1:0]        lc_wide;
  logic [POP_FW-1:0]    pop_out;

  assign col_wide  = CIW'(col_q);
  assign row_wide  = RIW'(row_q);
  assign on_grid   = (col_wide < CIW'(GRID_COLS)) && (row_wide < RIW'(GRID_ROWS));
  assign col_idx   = col_wide[COL_W-1:0];
  assign row_idx   = row_wide[ROW_W-1:0];
  assign col_mask  = GRID_COLS'(1) << col_idx;
  assign cur_bit   = on_grid && mem_rdata[col_idx];
  assign do_toggle = on_grid && (cmd_q == CMD_TOGGLE);

  // Neighbor count for the cell at bit 0 of the window; bit 1 is its right column,
  // which holds the wrapped first column at the right edge and counts as dead there.
  assign last_col = (col_cnt == COL_W'(GRID_COLS - 1));
  assign nbrs = 4'(la) + 4'(lc) + 4'(lb) + 4'(a_row[0]) + 4'(b_row[0])
              + 4'(a_row[1] && !last_col) + 4'(c_row[1] && !last_col)
              + 4'(b_row[1] && !last_col);
  assign cell_next = life_next(c_row[0], nbrs);

  // Saturate the reported population.
  assign lc_wide = PW'(live_count);
  assign pop_out = (lc_wide > PW'(POP_MAX)) ? POP_FW'(POP_MAX) : lc_wide[POP_FW-1:0];

  assign s_tready = (state == ST_IDLE);

  // RAM access per state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {bank, row_idx};
    mem_wdata = mem_rdata ^ col_mask;
    mem_raddr = {bank, row_idx};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = {1'b0, clr_row};
        mem_wdata = '0;
      end
      ST_CDAT: begin
        mem_we = do_toggle;
      end
      ST_SRD: begin
        mem_raddr = {bank, ld_row[ROW_W-1:0]};
      end
      ST_SWR: begin
        mem_we    = 1'b1;
        mem_waddr = {~bank, ROW_W'(ld_row - LDR_W'(1))};
        mem_wdata = new_row;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Each bank spans a power-of-two row range so {bank, row} stays inside the RAM.
  lge_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (2 * (1 << ROW_W))
  ) u_grid (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_row    <= '0;
      bank       <= 1'b0;
      live_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      // Drop the output word once taken, unless a new word loads in the same cycle.
      if (m_tvalid && m_tready && (state != ST_RESP)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        // Zero every row of bank 0 after reset.
        ST_CLEAR: begin
          clr_row <= clr_row + ROW_W'(1);
          if (clr_row == ROW_W'(GRID_ROWS - 1)) begin
            state <= ST_IDLE;
          end
        end

        ST_IDLE: begin
          if (s_tvalid) begin
            cmd_q <= s_tdata[CMD_FW-1:0];
            col_q <= s_tdata[CMD_FW +: COL_FW];
            row_q <= s_tdata[CMD_FW + COL_FW +: ROW_FW];
            if (s_tdata[CMD_FW-1:0] == CMD_STEP) begin
              ld_row  <= '0;
              a_row   <= '0;
              c_row   <= '0;
              b_row   <= '0;
              pop_acc <= '0;
              state   <= ST_SRD;
            end else begin
              state <= ST_CRD;
            end
          end
        end

        // Row of the addressed cell is being read.
        ST_CRD: begin
          state <= ST_CDAT;
        end

        // Read-modify-write of the addressed row.
        ST_CDAT: begin
          if (do_toggle) begin
            res_alive <= ~cur_bit;
            if (cur_bit) begin
              live_count <= live_count - POP_W'(1);
            end else begin
              live_count <= live_count + POP_W'(1);
            end
          end else begin
            res_alive <= cur_bit;
          end
          state <= ST_RESP;
        end

        // Hold until the output register is free.
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TDATA_W'({pop_out, res_alive});
            state    <= ST_IDLE;
          end
        end

        ST_SRD: begin
          state <= ST_SLD;
        end

        // Advance the window one row; rows past the bottom edge are dead.
        ST_SLD: begin
          a_row <= c_row;
          c_row <= b_row;
          b_row <= (ld_row == LDR_W'(GRID_ROWS)) ? '0 : mem_rdata;
          if (ld_row == '0) begin
            ld_row <= LDR_W'(1);
            state  <= ST_SRD;
          end else begin
            col_cnt <= '0;
            la      <= 1'b0;
            lc      <= 1'b0;
            lb      <= 1'b0;
            state   <= ST_SCOL;
          end
        end

        // One cell per cycle; rotate the window right so each row is whole again
        // after the last column.
        ST_SCOL: begin
          new_row <= {cell_next, new_row[GRID_COLS-1:1]};
          pop_acc <= pop_acc + POP_W'(cell_next);
          la      <= a_row[0];
          lc      <= c_row[0];
          lb      <= b_row[0];
          a_row   <= {a_row[0], a_row[GRID_COLS-1:1]};
          c_row   <= {c_row[0], c_row[GRID_COLS-1:1]};
          b_row   <= {b_row[0], b_row[GRID_COLS-1:1]};
          col_cnt <= col_cnt + COL_W'(1);
          if (last_col) begin
            state <= ST_SWR;
          end
        end

        // Next row goes to the other bank; swap banks after the last row.
        ST_SWR: begin
          if (ld_row == LDR_W'(GRID_ROWS)) begin
            bank       <= ~bank;
            live_count <= pop_acc;
            state      <= ST_CRD;
          end else begin
            ld_row <= ld_row + LDR_W'(1);
            state  <= ST_SRD;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
